// ===== hdl/bpc_pkg.sv =====
`default_nettype none

package bpc_pkg;

   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 60;
   localparam int CSR_W   = 24;

   localparam int UP_SHIFT   = 23;
   localparam int FILT_SHIFT = 16;
   localparam int VEL_SHIFT  = 24;

   localparam logic signed [MUL_A_W-1:0] COEF_OLD = 25'sd45875;
   localparam logic signed [MUL_A_W-1:0] COEF_NEW = 25'sd19661;

   typedef enum logic [2:0] {
      CSR_UPRIGHT_KP     = 3'd0,
      CSR_UPRIGHT_KD     = 3'd1,
      CSR_BALANCE_CENTER = 3'd2,
      CSR_VELOCITY_KP    = 3'd3,
      CSR_VELOCITY_KI    = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5,
      CSR_TILT_LIMIT     = 3'd6
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KP,
      ST_KD,
      ST_FOLD,
      ST_FNEW,
      ST_FSUM,
      ST_FDIV,
      ST_VKP,
      ST_VKI,
      ST_VSUM,
      ST_VDIV,
      ST_DONE
   } state_type;

   // signed shift right with rounding toward zero
   function automatic logic signed [ACC_W-1:0] trunc_shift(
      input logic signed [ACC_W-1:0] x,
      input int unsigned             sh
   );
      logic signed [ACC_W-1:0] bias;
      logic signed [ACC_W-1:0] sum;
      bias = x[ACC_W-1] ? ((ACC_W'(1) << sh) - ACC_W'(1)) : '0;
      sum  = x + bias;
      return sum >>> sh;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/balance_pd_pi_controller.sv =====
`default_nettype none

// Balance controller: upright PD term plus velocity PI term on a low-pass filtered
// wheel speed, sharing one 25x32 multiplier and one accumulator. A request is
// accepted only while idle and then steps through KP, KD, FOLD, FNEW, FSUM, FDIV,
// VKP, VKI, VSUM, VDIV and DONE; the next request is taken only after DONE has
// passed its result on. The six products go through the shared multiplier with
// accumulate and round steps in between. A finished result waits in the output
// register while the next request runs; the block holds its last step until that
// result is taken. Configuration registers are written through csr_we/csr_addr/
// csr_wdata; the user must write them only while idle, the block does not enforce it.
// motors_off reports the tilt cutoff; left and right drive are always equal.
module balance_pd_pi_controller (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [15:0]          req_pitch_angle,
   input  wire logic signed [15:0]          req_pitch_rate,
   input  wire logic signed [11:0]          req_left_speed,
   input  wire logic signed [11:0]          req_right_speed,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [15:0]               rsp_left_drive,
   output logic signed [15:0]               rsp_right_drive,
   output logic                             rsp_motors_off,
   input  wire logic                        csr_we,
   input  wire logic [2:0]                  csr_addr,
   input  wire logic [bpc_pkg::CSR_W-1:0]   csr_wdata
);

   bpc_pkg::state_type state_ff, state_in;

   logic signed [23:0] kp_ff, kd_ff, vkp_ff, vki_ff;
   logic signed [15:0] center_ff;
   logic [15:0]        ilim_ff;
   logic [14:0]        tilt_ff;

   logic signed [16:0] perr_ff, perr_in;
   logic signed [15:0] rate_ff, rate_in;
   logic signed [16:0] spd_ff, spd_in;
   logic [16:0]        apitch_ff, apitch_in;

   logic signed [bpc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [bpc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [bpc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [bpc_pkg::ACC_W-1:0]   acc_ff, acc_in;

   logic signed [25:0] up_ff, up_in;
   logic signed [33:0] vel_ff, vel_in;
   logic signed [31:0] filt_ff, filt_in;
   logic signed [31:0] integ_ff, integ_in;

   logic signed [32:0] lim_s;
   logic signed [32:0] integ_sum;
   logic signed [34:0] total;
   logic signed [15:0] drive_sat;
   logic               tilt_off, tilt_clear;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] drive_ff, drive_in;
   logic               off_ff, off_in;

   logic signed [12:0] wsum;

   assign lim_s      = {9'b0, ilim_ff, 8'b0};
   assign integ_sum  = 33'(integ_ff) + 33'(filt_ff);
   assign total      = 35'(up_ff) + 35'(vel_ff);
   assign tilt_off   = apitch_ff >= {2'b0, tilt_ff};
   assign tilt_clear = apitch_ff > {2'b0, tilt_ff};
   assign wsum       = 13'(req_left_speed) + 13'(req_right_speed);

   always_comb begin
      if (total > 35'sd32767) begin
         drive_sat = 16'sh7fff;
      end else if (total < -35'sd32768) begin
         drive_sat = -16'sh8000;
      end else begin
         drive_sat = 16'(total);
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         bpc_pkg::ST_KP: begin
            mul_a = 25'(kp_ff);
            mul_b = 32'(perr_ff);
         end
         bpc_pkg::ST_KD: begin
            mul_a = 25'(kd_ff);
            mul_b = {{9{rate_ff[15]}}, rate_ff, 7'b0};
         end
         bpc_pkg::ST_FOLD: begin
            mul_a = bpc_pkg::COEF_OLD;
            mul_b = filt_ff;
         end
         bpc_pkg::ST_FNEW: begin
            mul_a = bpc_pkg::COEF_NEW;
            mul_b = {{7{spd_ff[16]}}, spd_ff, 8'b0};
         end
         bpc_pkg::ST_VKP: begin
            mul_a = 25'(vkp_ff);
            mul_b = filt_ff;
         end
         bpc_pkg::ST_VKI: begin
            mul_a = 25'(vki_ff);
            mul_b = integ_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = bpc_pkg::PROD_W'(mul_a * mul_b);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      up_in        = up_ff;
      vel_in       = vel_ff;
      filt_in      = filt_ff;
      integ_in     = integ_ff;
      perr_in      = perr_ff;
      rate_in      = rate_ff;
      spd_in       = spd_ff;
      apitch_in    = apitch_ff;
      drive_in     = drive_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         bpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               perr_in   = 17'(req_pitch_angle) - 17'(center_ff);
               rate_in   = req_pitch_rate;
               spd_in    = (17'(wsum) <<< 3) + (17'(wsum) <<< 1);
               apitch_in = req_pitch_angle[15] ? 17'(-17'(req_pitch_angle))
                                               : 17'(req_pitch_angle);
               state_in  = bpc_pkg::ST_KP;
            end
         end
         bpc_pkg::ST_KP: begin
            state_in = bpc_pkg::ST_KD;
         end
         bpc_pkg::ST_KD: begin
            acc_in   = bpc_pkg::ACC_W'(prod_ff);
            state_in = bpc_pkg::ST_FOLD;
         end
         bpc_pkg::ST_FOLD: begin
            acc_in   = acc_ff + bpc_pkg::ACC_W'(prod_ff);
            state_in = bpc_pkg::ST_FNEW;
         end
         bpc_pkg::ST_FNEW: begin
            up_in    = 26'(bpc_pkg::trunc_shift(acc_ff, bpc_pkg::UP_SHIFT));
            acc_in   = bpc_pkg::ACC_W'(prod_ff);
            state_in = bpc_pkg::ST_FSUM;
         end
         bpc_pkg::ST_FSUM: begin
            acc_in   = acc_ff + bpc_pkg::ACC_W'(prod_ff);
            state_in = bpc_pkg::ST_FDIV;
         end
         bpc_pkg::ST_FDIV: begin
            filt_in  = 32'(bpc_pkg::trunc_shift(acc_ff, bpc_pkg::FILT_SHIFT));
            state_in = bpc_pkg::ST_VKP;
         end
         bpc_pkg::ST_VKP: begin
            if (integ_sum > lim_s) begin
               integ_in = 32'(lim_s);
            end else if (integ_sum < -lim_s) begin
               integ_in = 32'(-lim_s);
            end else begin
               integ_in = 32'(integ_sum);
            end
            state_in = bpc_pkg::ST_VKI;
         end
         bpc_pkg::ST_VKI: begin
            acc_in   = bpc_pkg::ACC_W'(prod_ff);
            state_in = bpc_pkg::ST_VSUM;
         end
         bpc_pkg::ST_VSUM: begin
            acc_in   = acc_ff + bpc_pkg::ACC_W'(prod_ff);
            state_in = bpc_pkg::ST_VDIV;
         end
         bpc_pkg::ST_VDIV: begin
            vel_in   = 34'(bpc_pkg::trunc_shift(acc_ff, bpc_pkg::VEL_SHIFT));
            state_in = bpc_pkg::ST_DONE;
         end
         bpc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               drive_in     = tilt_off ? 16'sd0 : drive_sat;
               off_in       = tilt_off;
               rsp_valid_in = 1'b1;
               if (tilt_clear) begin
                  integ_in = '0;
               end
               state_in = bpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         filt_ff      <= '0;
         integ_ff     <= '0;
         kp_ff        <= 24'sd5242880;
         kd_ff        <= 24'sd26214;
         center_ff    <= -16'sd640;
         vkp_ff       <= 24'sd327680;
         vki_ff       <= 24'sd1966;
         ilim_ff      <= 16'd1200;
         tilt_ff      <= 15'd6400;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         filt_ff      <= filt_in;
         integ_ff     <= integ_in;
         if (csr_we) begin
            unique case (csr_addr)
               bpc_pkg::CSR_UPRIGHT_KP:     kp_ff     <= csr_wdata;
               bpc_pkg::CSR_UPRIGHT_KD:     kd_ff     <= csr_wdata;
               bpc_pkg::CSR_BALANCE_CENTER: center_ff <= csr_wdata[15:0];
               bpc_pkg::CSR_VELOCITY_KP:    vkp_ff    <= csr_wdata;
               bpc_pkg::CSR_VELOCITY_KI:    vki_ff    <= csr_wdata;
               bpc_pkg::CSR_INTEGRAL_LIMIT: ilim_ff   <= csr_wdata[15:0];
               bpc_pkg::CSR_TILT_LIMIT:     tilt_ff   <= csr_wdata[14:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      up_ff     <= up_in;
      vel_ff    <= vel_in;
      perr_ff   <= perr_in;
      rate_ff   <= rate_in;
      spd_ff    <= spd_in;
      apitch_ff <= apitch_in;
      drive_ff  <= drive_in;
      off_ff    <= off_in;
   end

   assign req_ready       = state_ff == bpc_pkg::ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = drive_ff;
   assign rsp_right_drive = drive_ff;
   assign rsp_motors_off  = off_ff;

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == bpc_pkg::ST_KP)
      else $error("request accepted without starting the sequence");

   a_integ_clamp: assert property (@(posedge clock) disable iff (reset)
      state_ff == bpc_pkg::ST_VKI |-> (33'(integ_ff) <= lim_s) && (33'(integ_ff) >= -lim_s))
      else $error("speed integral outside its clamp");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motors_off |-> rsp_left_drive == 16'sd0)
      else $error("drive not zero under tilt cutoff");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == bpc_pkg::ST_DONE && rsp_valid && !rsp_ready |=> state_ff == bpc_pkg::ST_DONE)
      else $error("pending response overwritten");

endmodule

`default_nettype wire
